/* rtl/core/fcbc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the framed block check.
package fcbc_pkg;

  // Frame control codes.
  localparam logic [7:0] CODE_DLE = 8'h10;
  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;

  // Shifted-register mask and feedback bit of the reflected 0xA001 polynomial.
  localparam logic [15:0] KEEP_MASK = 16'h5FFE;
  localparam logic [15:0] BIT_ONE   = 16'h0001;

  // Configuration port geometry: one 32-bit register per word.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0] REG_CRC_INITIAL = 1'b0;

  // Queue between the front and back parts.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       last_byte;
    logic       skip;
    logic       is_etx;
  } fcbc_entry_t;

  // Queue status seen by the front part, the back part and the top level.
  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [FIFO_CNT_W-1:0] count;
  } fcbc_fifo_status_t;

  // Eight serial steps of the reflected CRC, least significant data bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    logic        b0;
    logic        b13;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb  = c[0] ^ data[k];
      b0  = c[1] ^ fb;
      b13 = c[14] ^ fb;
      c   = (c >> 1) & KEEP_MASK;
      c   = c | {fb, 1'b0, b13, 12'd0, b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/fcbc_front.sv */
// Front part: accepts input transactions, classifies the byte and pushes it into the queue.
module fcbc_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_frame_start,
  input  logic                          in_last_byte,
  input  fcbc_pkg::fcbc_fifo_status_t   fifo_status,
  output logic                          push,
  output fcbc_pkg::fcbc_entry_t         push_entry
);
  import fcbc_pkg::*;

  // Take a byte whenever the queue has room.
  assign in_ready = !fifo_status.full;
  assign push     = in_valid && in_ready;

  // Control bytes that never enter the CRC, and the end-of-text code.
  always_comb begin
    push_entry.data_byte   = in_data_byte;
    push_entry.frame_start = in_frame_start;
    push_entry.last_byte   = in_last_byte;
    push_entry.skip        = (in_data_byte == CODE_DLE) || (in_data_byte == CODE_SOH) ||
                             (in_data_byte == CODE_STX);
    push_entry.is_etx      = (in_data_byte == CODE_ETX);
  end

endmodule

/* rtl/core/fcbc_fifo.sv */
// Short queue of classified bytes between the front and back parts.
module fcbc_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  fcbc_pkg::fcbc_entry_t         push_entry,
  input  logic                          pop,
  output fcbc_pkg::fcbc_entry_t         pop_entry,
  output fcbc_pkg::fcbc_fifo_status_t   status
);
  import fcbc_pkg::*;

  fcbc_entry_t           mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  // Pointer advance with wrap at the queue depth.
  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + FIFO_PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - FIFO_CNT_W'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry    = mem_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

/* rtl/core/fcbc_back.sv */
// Back part: frame state, CRC update and the result output register.
module fcbc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcbc_pkg::fcbc_fifo_status_t   fifo_status,
  input  fcbc_pkg::fcbc_entry_t         pop_entry,
  output logic                          pop,
  input  logic [15:0]                   crc_initial,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_crc_value,
  output logic                          out_byte_counted,
  output logic                          out_frame_done
);
  import fcbc_pkg::*;

  logic [15:0] running_crc_r, running_crc_nxt;
  logic        stopped_r, stopped_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_crc_r;
  logic        out_counted_r;
  logic        out_done_r;

  logic [15:0] crc_base;
  logic        stop_base;
  logic        active;
  logic        counted;

  // Pop when the output register is free or is being emptied this cycle.
  assign pop = !fifo_status.empty && (!out_valid_r || out_ready);

  // A start reloads the CRC first; a stopped frame ignores the byte.
  always_comb begin
    crc_base        = pop_entry.frame_start ? crc_initial : running_crc_r;
    stop_base       = pop_entry.frame_start ? 1'b0 : stopped_r;
    active          = !stop_base;
    counted         = active && !pop_entry.skip;
    running_crc_nxt = counted ? crc_byte(crc_base, pop_entry.data_byte) : crc_base;
    stopped_nxt     = stop_base || (active && (pop_entry.is_etx || pop_entry.last_byte));
    out_valid_nxt   = pop || (out_valid_r && !out_ready);
  end

  // Frame state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= '0;
      stopped_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        running_crc_r <= running_crc_nxt;
        stopped_r     <= stopped_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_crc_r     <= running_crc_nxt;
      out_counted_r <= counted;
      out_done_r    <= stopped_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_crc_value    = out_crc_r;
  assign out_byte_counted = out_counted_r;
  assign out_frame_done   = out_done_r;

endmodule

/* rtl/core/framed_crc16_block_check.sv */
// Top level of the framed CRC-16 block check: register port, front, queue and back.
//
//   Channel   Handshake             Payload
//   in_       in_valid / in_ready   in_data_byte[7:0], in_frame_start, in_last_byte
//   out_      out_valid / out_ready out_crc_value[15:0], out_byte_counted, out_frame_done
//   config    psel/penable/pwrite   paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// One byte per cycle sustained while out_ready stays high; the whole eight-bit CRC
// update is combinational XOR logic in the back part. An accepted byte is first
// written into the two-entry queue, and its CRC update loads the output register
// when the byte is popped from the queue, which sets out_valid.
// Synchronous active-low reset clears the CRC, the frame state, the queue and
// crc_initial. A stalled output holds one result in the output register and up
// to two bytes in the queue before in_ready drops.
module framed_crc16_block_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_frame_start,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_crc_value,
  output logic                          out_byte_counted,
  output logic                          out_frame_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcbc_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcbc_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcbc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import fcbc_pkg::*;

  logic              [15:0] crc_initial_r;
  logic                     push;
  logic                     pop;
  fcbc_entry_t              push_entry;
  fcbc_entry_t              pop_entry;
  fcbc_fifo_status_t        fifo_status;
  logic                     reg_sel_init;

  // Register port: no wait states, one register at word 0.
  assign pready       = 1'b1;
  assign reg_sel_init = (paddr[2:2] == REG_CRC_INITIAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_initial_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel_init) begin
      crc_initial_r <= pwdata[15:0];
    end
  end

  assign prdata = reg_sel_init ? {16'd0, crc_initial_r} : '0;

  fcbc_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .in_last_byte   (in_last_byte),
    .fifo_status    (fifo_status),
    .push           (push),
    .push_entry     (push_entry)
  );

  fcbc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (fifo_status)
  );

  fcbc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_status      (fifo_status),
    .pop_entry        (pop_entry),
    .pop              (pop),
    .crc_initial      (crc_initial_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_crc_value    (out_crc_value),
    .out_byte_counted (out_byte_counted),
    .out_frame_done   (out_frame_done)
  );

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An accepted byte is held in the queue in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) push |=> !fifo_status.empty)
    else $error("accepted byte lost from queue");

  // A byte taken from the queue shows up as a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) pop |=> out_valid)
    else $error("popped byte did not reach the output register");

  // A frame that is done never reports a byte as counted without a new start.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop && !pop_entry.frame_start && u_back.stopped_r |=>
      out_valid && !out_byte_counted && out_frame_done)
    else $error("byte counted after the frame ended");

endmodule
